// ===== rtl/ntcrs_pkg.sv =====
// Shared types and constants for the nearest tile class ring search.
// Used by ntcrs_ctrl, ntcrs_dpath and the top level; no dependencies.
package ntcrs_pkg;

	localparam int DIST_W = 10;

	localparam logic [DIST_W-1:0] WATER_LIMIT = 10'h07F;
	localparam logic [DIST_W-1:0] LAND_LIMIT  = 10'h200;
	localparam logic [DIST_W-1:0] LAND_EXISTS = 10'h1FF;

	localparam logic [1:0] KIND_WATER = 2'd1;
	localparam logic [1:0] KIND_VOID  = 2'd2;

	localparam logic [1:0] REG_LOG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_LOG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_FREEFORM   = 2'd2;

	localparam logic       ACT_WRITE = 1'b0;
	localparam logic       ACT_QUERY = 1'b1;

	// ring walk directions: SW, SE, NE, NW legs
	localparam logic signed [1:0] STEP_DX [4] = '{-2'sd1, 2'sd1, 2'sd1, -2'sd1};
	localparam logic signed [1:0] STEP_DY [4] = '{2'sd1, 2'sd1, -2'sd1, -2'sd1};
	localparam logic [1:0] DIR_LAST = 2'd3;

	typedef enum logic [2:0] {
		RES_ZERO,
		RES_HIT,
		RES_WATER_LIM,
		RES_LAND_EXISTS,
		RES_LAND_LIM
	} res_sel_t;

	typedef struct packed {
		logic     wr;
		logic     load;
		logic     walk;
		logic     scan_clr;
		logic     scan;
		logic     res_en;
		res_sel_t res_sel;
	} ntcrs_cmd_t;

	typedef struct packed {
		logic origin_match;
		logic ring_hit;
		logic walk_last;
		logic land_hit;
		logic scan_last;
		logic want;
	} ntcrs_sts_t;

endpackage

// ===== rtl/ntcrs_ctrl.sv =====
// Sequencer for the ring search: decodes items and steps the datapath.
// Depends on ntcrs_pkg.
module ntcrs_ctrl import ntcrs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       action,
	input  ntcrs_sts_t sts,
	output ntcrs_cmd_t cmd,
	output logic       busy,
	output logic       done
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ORIGIN,
		ST_RING,
		ST_RING_DRAIN,
		ST_SCAN,
		ST_SCAN_DRAIN
	} state_t;

	state_t state_q, state_nx;
	logic   busy_q, done_q;

	always_comb begin
		cmd      = '0;
		cmd.res_sel = RES_ZERO;
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (action == ACT_QUERY) begin
						cmd.load = 1'b1;
						state_nx = ST_ORIGIN;
					end else begin
						cmd.wr = 1'b1;
					end
				end
			end
			ST_ORIGIN: begin
				if (sts.origin_match) begin
					cmd.res_en  = 1'b1;
					cmd.res_sel = RES_ZERO;
					state_nx    = ST_IDLE;
				end else begin
					state_nx = ST_RING;
				end
			end
			ST_RING: begin
				if (sts.ring_hit) begin
					cmd.res_en  = 1'b1;
					cmd.res_sel = RES_HIT;
					state_nx    = ST_IDLE;
				end else begin
					cmd.walk = 1'b1;
					if (sts.walk_last)
						state_nx = ST_RING_DRAIN;
				end
			end
			ST_RING_DRAIN: begin
				if (sts.ring_hit) begin
					cmd.res_en  = 1'b1;
					cmd.res_sel = RES_HIT;
					state_nx    = ST_IDLE;
				end else if (sts.want) begin
					cmd.res_en  = 1'b1;
					cmd.res_sel = RES_WATER_LIM;
					state_nx    = ST_IDLE;
				end else begin
					cmd.scan_clr = 1'b1;
					state_nx     = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.land_hit) begin
					cmd.res_en  = 1'b1;
					cmd.res_sel = RES_LAND_EXISTS;
					state_nx    = ST_IDLE;
				end else begin
					cmd.scan = 1'b1;
					if (sts.scan_last)
						state_nx = ST_SCAN_DRAIN;
				end
			end
			ST_SCAN_DRAIN: begin
				cmd.res_en  = 1'b1;
				cmd.res_sel = sts.land_hit ? RES_LAND_EXISTS : RES_LAND_LIM;
				state_nx    = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			busy_q  <= (state_nx != ST_IDLE);
			done_q  <= cmd.res_en;
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

// ===== rtl/ntcrs_dpath.sv =====
// Datapath: config registers, tile memory, ring walker, map scan counter.
// Depends on ntcrs_pkg; driven by ntcrs_ctrl commands.
module ntcrs_dpath import ntcrs_pkg::*; #(
	parameter int MAX_LOG_SIDE = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [1:0]        cfg_index,
	input  logic [2:0]        cfg_data,
	input  logic [5:0]        tile_x,
	input  logic [5:0]        tile_y,
	input  logic              water_ground,
	input  logic [1:0]        tile_kind,
	input  logic              seek_water,
	input  ntcrs_cmd_t        cmd,
	output ntcrs_sts_t        sts,
	output logic [DIST_W-1:0] distance
);

	localparam int SIDE_W  = MAX_LOG_SIDE;
	localparam int ADDR_W  = 2 * MAX_LOG_SIDE;
	localparam int DEPTH   = 1 << ADDR_W;
	localparam int LOG_W   = $clog2(MAX_LOG_SIDE + 1);
	localparam int IN_W    = (MAX_LOG_SIDE > 6) ? MAX_LOG_SIDE : 6;
	localparam int COORD_W = ((MAX_LOG_SIDE > 10) ? MAX_LOG_SIDE : 10) + 2;
	localparam int SUM_W   = MAX_LOG_SIDE + 2;
	localparam int CMP_W   = (SUM_W > DIST_W + 1) ? SUM_W : DIST_W + 1;

	// configuration
	logic [2:0]       lw_q, lh_q;
	logic             ff_q;
	logic [LOG_W-1:0] lw_c, lh_c;
	logic [LOG_W:0]   lsum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_q <= 3'd6;
			lh_q <= 3'd6;
			ff_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_LOG_WIDTH:  lw_q <= cfg_data;
				REG_LOG_HEIGHT: lh_q <= cfg_data;
				REG_FREEFORM:   ff_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (lw_q == 3'd0)
			lw_c = LOG_W'(1);
		else if (int'(lw_q) > MAX_LOG_SIDE)
			lw_c = LOG_W'(MAX_LOG_SIDE);
		else
			lw_c = LOG_W'(lw_q);
		if (lh_q == 3'd0)
			lh_c = LOG_W'(1);
		else if (int'(lh_q) > MAX_LOG_SIDE)
			lh_c = LOG_W'(MAX_LOG_SIDE);
		else
			lh_c = LOG_W'(lh_q);
	end

	assign lsum = (LOG_W + 1)'(lw_c) + (LOG_W + 1)'(lh_c);

	// input coordinates, wrapped to the map
	logic [IN_W-1:0]   xin_w, yin_w;
	logic [SIDE_W-1:0] xin, yin, wmask, hmask;
	logic [ADDR_W-1:0] in_addr;

	assign wmask   = ~({SIDE_W{1'b1}} << lw_c);
	assign hmask   = ~({SIDE_W{1'b1}} << lh_c);
	assign xin_w   = IN_W'(tile_x);
	assign yin_w   = IN_W'(tile_y);
	assign xin     = xin_w[SIDE_W-1:0] & wmask;
	assign yin     = yin_w[SIDE_W-1:0] & hmask;
	assign in_addr = (ADDR_W'(yin) << lw_c) | ADDR_W'(xin);

	// ring walker
	logic signed [COORD_W-1:0] x_q, y_q;
	logic signed [COORD_W-1:0] lo_s, wl_s, hl_s;
	logic [COORD_W-1:0]        w_u, h_u;
	logic [DIST_W-1:0]         dist_q, dist_nx, limit, dist_s1;
	logic [DIST_W-1:0]         step_q;
	logic [1:0]                dir_q;
	logic                      want_q, inb, side_end, ring_end, more_rings;
	logic [SUM_W-1:0]          sum_wh;
	logic [ADDR_W-1:0]         walk_addr;

	assign w_u     = COORD_W'(1) << lw_c;
	assign h_u     = COORD_W'(1) << lh_c;
	assign wl_s    = $signed(w_u - COORD_W'(1));
	assign hl_s    = $signed(h_u - COORD_W'(1));
	assign lo_s    = $signed(COORD_W'(ff_q));
	assign inb     = (x_q >= lo_s) && (x_q < wl_s) && (y_q >= lo_s) && (y_q < hl_s);
	assign sum_wh  = (SUM_W'(1) << lw_c) + (SUM_W'(1) << lh_c);
	assign limit   = want_q ? WATER_LIMIT : LAND_LIMIT;
	assign dist_nx = dist_q + DIST_W'(1);
	assign more_rings = (dist_nx < limit) && (CMP_W'(dist_nx) <= CMP_W'(sum_wh));
	assign side_end = (step_q == dist_q - DIST_W'(1));
	assign ring_end = side_end && (dir_q == DIR_LAST);
	assign walk_addr = (ADDR_W'(y_q[SIDE_W-1:0]) << lw_c) | ADDR_W'(x_q[SIDE_W-1:0]);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= $signed(COORD_W'(xin));
			y_q    <= $signed(COORD_W'(yin)) - COORD_W'(1);
			dist_q <= DIST_W'(1);
			step_q <= '0;
			dir_q  <= '0;
			want_q <= seek_water;
		end else if (cmd.walk) begin
			x_q <= x_q + COORD_W'(STEP_DX[dir_q]);
			// after the closing leg, drop one row to start the next ring
			y_q <= y_q + COORD_W'(STEP_DY[dir_q]) - (ring_end ? COORD_W'(1) : COORD_W'(0));
			if (side_end) begin
				step_q <= '0;
				dir_q  <= dir_q + 2'd1;
				if (ring_end)
					dist_q <= dist_nx;
			end else begin
				step_q <= step_q + DIST_W'(1);
			end
		end
		if (cmd.walk)
			dist_s1 <= dist_q;
	end

	// whole-map scan for any land-kind tile
	logic [ADDR_W-1:0] scan_q, nmask;

	assign nmask = ~({ADDR_W{1'b1}} << lsum);

	always_ff @(posedge clk) begin
		if (cmd.scan_clr)
			scan_q <= '0;
		else if (cmd.scan)
			scan_q <= scan_q + ADDR_W'(1);
	end

	// tile memory, one write port and one read port, registered read
	logic [2:0]        tile_mem_q [DEPTH];
	logic [2:0]        rdata_q;
	logic [ADDR_W-1:0] raddr;
	logic              vld_s1;

	always_comb begin
		if (cmd.load)
			raddr = in_addr;
		else if (cmd.scan)
			raddr = scan_q;
		else
			raddr = walk_addr;
	end

	always_ff @(posedge clk) begin
		if (cmd.wr)
			tile_mem_q[in_addr] <= {tile_kind, water_ground};
		rdata_q <= tile_mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= (cmd.walk && inb) || cmd.scan;
	end

	assign sts.origin_match = (rdata_q[0] == want_q);
	assign sts.ring_hit     = vld_s1 && (rdata_q[0] == want_q);
	assign sts.walk_last    = ring_end && !more_rings;
	assign sts.land_hit     = vld_s1 && (rdata_q[2:1] != KIND_VOID)
	                          && (rdata_q[2:1] != KIND_WATER);
	assign sts.scan_last    = (scan_q == nmask);
	assign sts.want         = want_q;

	// result register
	logic [DIST_W-1:0] distance_q;

	always_ff @(posedge clk) begin
		if (cmd.res_en) begin
			case (cmd.res_sel)
				RES_ZERO:        distance_q <= '0;
				RES_HIT:         distance_q <= dist_s1;
				RES_WATER_LIM:   distance_q <= WATER_LIMIT;
				RES_LAND_EXISTS: distance_q <= LAND_EXISTS;
				RES_LAND_LIM:    distance_q <= LAND_LIMIT;
				default:         distance_q <= '0;
			endcase
		end
	end

	assign distance = distance_q;

endmodule

// ===== rtl/nearest_tile_class_ring_search.sv =====
// Top level of the nearest tile class ring search.
// Depends on ntcrs_pkg, ntcrs_ctrl and ntcrs_dpath.
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------------
//  item in   | start, busy          | action, tile_x, tile_y, water_ground,
//            |                      | tile_kind, seek_water
//  result    | done (1-cycle pulse) | distance
//  config    | cfg_write            | cfg_index, cfg_data
//
// An item transfers on a rising edge with start high and busy low.
// A tile write gives no result; busy stays low.
// A query first reads the origin tile, then walks the ring positions in turn
// (4*d positions on ring d) and drains the last read; a land query that finds
// nothing adds a scan of the whole map, 2^(log_width+log_height) tiles.
// The single read port of the tile memory reads one tile per cycle.
// Reset clears the sequencer and config (6, 6, 0); the tile memory is not cleared.
// done is high for exactly one cycle per query; the receiver cannot stall it.
module nearest_tile_class_ring_search import ntcrs_pkg::*; #(
	parameter int MAX_LOG_SIDE = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              action,
	input  logic [5:0]        tile_x,
	input  logic [5:0]        tile_y,
	input  logic              water_ground,
	input  logic [1:0]        tile_kind,
	input  logic              seek_water,
	output logic              done,
	output logic [DIST_W-1:0] distance,
	input  logic              cfg_write,
	input  logic [1:0]        cfg_index,
	input  logic [2:0]        cfg_data
);

	ntcrs_cmd_t cmd;
	ntcrs_sts_t sts;

	// sequencer: origin check, ring walk, land scan
	ntcrs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// memory, walker and result register
	ntcrs_dpath #(
		.MAX_LOG_SIDE (MAX_LOG_SIDE)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.tile_x       (tile_x),
		.tile_y       (tile_y),
		.water_ground (water_ground),
		.tile_kind    (tile_kind),
		.seek_water   (seek_water),
		.cmd          (cmd),
		.sts          (sts),
		.distance     (distance)
	);

	// a result only appears as the sequencer returns to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// two results never follow back to back
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe repeated");

	// an accepted query keeps the block busy in the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action == ACT_QUERY) |=> busy)
		else $error("query transfer did not start a search");

	// a tile write completes at once and yields nothing
	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action != ACT_QUERY) |=> (!busy && !done))
		else $error("tile write produced activity");

endmodule
